### sv/gibdr_pkg.sv
package gibdr_pkg;

  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_LOAD = 2'd0;
  localparam logic [STATE_W-1:0] ST_RANK = 2'd1;
  localparam logic [STATE_W-1:0] ST_SCAN = 2'd2;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANKS_IN_NODE = 4'd1;

  localparam int PE_W      = 12;
  localparam int NRANK_W   = 5;
  localparam int LIMIT_W   = 7;
  localparam int PAYLOAD_W = 32;
  localparam int RANK_W    = 4;
  localparam int SEG_W     = 7;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage

### sv/group_items_by_dest_rank.sv
// Groups the items of one message by local destination rank.
// Input beats carry a payload, a global destination element and a last_item
// mark. A beat's rank is dest_pe minus first_pe; beats outside the node, or
// beats arriving once MSG_CAPACITY items are held, are dropped.
// Loading takes one beat per cycle. The beat marked last closes the message;
// if any item is held, in_stall then rises and the block emits every held
// payload grouped by ascending rank, in arrival order within a rank, each with
// its rank and the end offset of its segment; last_out marks the final output
// beat. Emission walks the item store through its single read port: it
// examines the ranks in turn and, for each rank that holds items, scans the
// store entries from the first up to that rank's last item. Between the last
// input beat and out_valid lie the rank state, the scan state with its
// registered store read, and the output register; empty ranks below the first
// used one and entries scanned ahead of a rank's first item delay it further.
// When the receiver holds out_stall high the walk pauses on the next matching
// item and resumes when the beat is taken. Input is accepted again in the
// cycle after the final beat is registered. The configuration port is always
// ready; write it only while idle. Reset clears the counts and the fill level
// and returns first_pe to 0 and ranks_in_node to 1.
module group_items_by_dest_rank import gibdr_pkg::*; #(
  parameter int MSG_CAPACITY = 64,
  parameter int MAX_RANKS    = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PAYLOAD_W-1:0]  in_payload,
  input  logic [PE_W-1:0]       in_dest_pe,
  input  logic                  in_last_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PAYLOAD_W-1:0]  out_sorted_payload,
  output logic [RANK_W-1:0]     out_rank,
  output logic [SEG_W-1:0]      out_segment_end,
  output logic                  out_last_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW     = $clog2(MSG_CAPACITY);
  localparam int FILL_W = $clog2(MSG_CAPACITY + 1);
  localparam int RW     = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
  localparam int SW     = (PAYLOAD_BITS < PAYLOAD_W) ? PAYLOAD_BITS : PAYLOAD_W;
  localparam logic [FILL_W-1:0]  CAP_L       = FILL_W'(MSG_CAPACITY);
  localparam logic [LIMIT_W-1:0] MAX_RANKS_L = LIMIT_W'(MAX_RANKS);

  logic [PE_W-1:0]    first_pe_r;
  logic [NRANK_W-1:0] ranks_in_node_r;

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [RW-1:0]      cur_rank_r, cur_rank_nxt;
  logic [FILL_W-1:0]  seg_end_r, seg_end_nxt;
  logic [FILL_W-1:0]  remain_r, remain_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [FILL_W-1:0]  counts_r [MAX_RANKS];

  logic               out_valid_r;
  logic [SW-1:0]      out_data_r;
  logic [RW-1:0]      out_rank_r;
  logic [FILL_W-1:0]  out_seg_r;
  logic               out_last_r;

  logic               in_acc;
  logic [PE_W-1:0]    rk;
  logic [LIMIT_W-1:0] limit;
  logic               in_node;
  logic               store_en;
  logic [RW-1:0]      cnt_addr;
  logic [FILL_W-1:0]  cnt_rd;
  logic               cnt_inc;
  logic               clear_msg;
  logic               out_free;
  logic               place;
  logic               place_last;
  logic               match;
  store_ctl_t         st_ctl;
  logic [AW-1:0]      rd_addr;
  logic [SW-1:0]      rd_data;
  logic [RW-1:0]      rd_rank;
  logic [SW+PAYLOAD_W-1:0]  pay_ext;
  logic [RW+RANK_W-1:0]     rank_ext;
  logic [FILL_W+SEG_W-1:0]  seg_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;

  assign rk    = in_dest_pe - first_pe_r;
  assign limit = ({2'b0, ranks_in_node_r} < MAX_RANKS_L) ? {2'b0, ranks_in_node_r}
                                                          : MAX_RANKS_L;
  assign in_node  = (in_dest_pe >= first_pe_r) &&
                    ({1'b0, rk} < {{(PE_W + 1 - LIMIT_W){1'b0}}, limit});
  assign store_en = in_acc && in_node && (fill_r < CAP_L);

  assign cnt_addr = (state_r == ST_LOAD) ? rk[RW-1:0] : cur_rank_r;
  assign cnt_rd   = counts_r[cnt_addr];
  assign cnt_inc  = store_en;

  assign out_free   = !out_valid_r || !out_stall;
  assign match      = (rd_rank == cur_rank_r);
  assign place      = (state_r == ST_SCAN) && match && out_free;
  assign place_last = (remain_r == FILL_W'(1)) && (seg_end_r == fill_r);

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    cur_rank_nxt = cur_rank_r;
    seg_end_nxt  = seg_end_r;
    remain_nxt   = remain_r;
    idx_nxt      = idx_r;
    clear_msg    = 1'b0;
    st_ctl.wr_en = store_en;
    st_ctl.rd_en = 1'b0;
    rd_addr      = idx_r;
    case (state_r)
      ST_LOAD: begin
        if (store_en) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        if (in_acc && in_last_item) begin
          if (fill_nxt == '0) begin
            clear_msg = 1'b1;
          end else begin
            state_nxt    = ST_RANK;
            cur_rank_nxt = '0;
            seg_end_nxt  = '0;
          end
        end
      end
      ST_RANK: begin
        if (cnt_rd == '0) begin
          cur_rank_nxt = cur_rank_r + RW'(1);
        end else begin
          seg_end_nxt  = seg_end_r + cnt_rd;
          remain_nxt   = cnt_rd;
          idx_nxt      = '0;
          rd_addr      = '0;
          st_ctl.rd_en = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (place && remain_r == FILL_W'(1)) begin
          if (seg_end_r == fill_r) begin
            clear_msg = 1'b1;
            fill_nxt  = '0;
            state_nxt = ST_LOAD;
          end else begin
            cur_rank_nxt = cur_rank_r + RW'(1);
            state_nxt    = ST_RANK;
          end
        end else if (place || !match) begin
          if (place) begin
            remain_nxt = remain_r - FILL_W'(1);
          end
          idx_nxt      = idx_r + AW'(1);
          rd_addr      = idx_r + AW'(1);
          st_ctl.rd_en = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_LOAD;
      fill_r          <= '0;
      cur_rank_r      <= '0;
      seg_end_r       <= '0;
      remain_r        <= '0;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
      first_pe_r      <= '0;
      ranks_in_node_r <= NRANK_W'(1);
      for (int i = 0; i < MAX_RANKS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      cur_rank_r <= cur_rank_nxt;
      seg_end_r  <= seg_end_nxt;
      remain_r   <= remain_nxt;
      idx_r      <= idx_nxt;
      if (clear_msg) begin
        for (int i = 0; i < MAX_RANKS; i++) begin
          counts_r[i] <= '0;
        end
      end else if (cnt_inc) begin
        counts_r[cnt_addr] <= cnt_rd + FILL_W'(1);
      end
      if (place) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST_PE) begin
          first_pe_r <= cfg_wdata[PE_W-1:0];
        end else if (cfg_index == CFG_RANKS_IN_NODE) begin
          ranks_in_node_r <= cfg_wdata[NRANK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      out_data_r <= rd_data;
      out_rank_r <= cur_rank_r;
      out_seg_r  <= seg_end_r;
      out_last_r <= place_last;
    end
  end

  gibdr_store #(
    .DEPTH  (MSG_CAPACITY),
    .DATA_W (SW),
    .RK_W   (RW)
  ) u_store (
    .clk     (clk),
    .ctl     (st_ctl),
    .wr_addr (fill_r[AW-1:0]),
    .wr_data (in_payload[SW-1:0]),
    .wr_rank (rk[RW-1:0]),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_rank (rd_rank)
  );

  assign pay_ext  = {{PAYLOAD_W{1'b0}}, out_data_r};
  assign rank_ext = {{RANK_W{1'b0}}, out_rank_r};
  assign seg_ext  = {{SEG_W{1'b0}}, out_seg_r};

  assign out_valid          = out_valid_r;
  assign out_sorted_payload = pay_ext[PAYLOAD_W-1:0];
  assign out_rank           = rank_ext[RANK_W-1:0];
  assign out_segment_end    = seg_ext[SEG_W-1:0];
  assign out_last_out       = out_last_r;

endmodule

### sv/gibdr_store.sv
module gibdr_store import gibdr_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 32,
  parameter int RK_W   = 4
) (
  input  logic                     clk,
  input  store_ctl_t               ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [RK_W-1:0]          wr_rank,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data,
  output logic [RK_W-1:0]          rd_rank
);

  logic [DATA_W-1:0] item_mem [DEPTH];
  logic [RK_W-1:0]   rank_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      item_mem[wr_addr] <= wr_data;
      rank_mem[wr_addr] <= wr_rank;
    end
    if (ctl.rd_en) begin
      rd_data <= item_mem[rd_addr];
      rd_rank <= rank_mem[rd_addr];
    end
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import gibdr_pkg::*;

  localparam int MSG_CAP     = 64;
  localparam int NUM_RANKS   = 16;
  localparam int SETTLE      = 40;
  localparam int PHASE_ITEMS = 62;

  typedef struct {
    logic [PAYLOAD_W-1:0] payload;
    logic [RANK_W-1:0]    rank;
    logic [SEG_W-1:0]     seg_end;
    logic                 last;
  } sorted_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PAYLOAD_W-1:0]  in_payload;
  logic [PE_W-1:0]       in_dest_pe;
  logic                  in_last_item;
  logic                  out_valid;
  logic                  out_stall;
  logic [PAYLOAD_W-1:0]  out_sorted_payload;
  logic [RANK_W-1:0]     out_rank;
  logic [SEG_W-1:0]      out_segment_end;
  logic                  out_last_out;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;

  logic [PE_W-1:0]      node_first_pe;
  logic [NRANK_W-1:0]   node_ranks;
  logic [PAYLOAD_W-1:0] held_payload [MSG_CAP];
  logic [RANK_W-1:0]    held_rank    [MSG_CAP];
  int                   rank_count   [NUM_RANKS];
  int                   held_fill;

  sorted_beat_t pending_sorted [$];

  group_items_by_dest_rank uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_payload         (in_payload),
    .in_dest_pe         (in_dest_pe),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_sorted_payload (out_sorted_payload),
    .out_rank           (out_rank),
    .out_segment_end    (out_segment_end),
    .out_last_out       (out_last_out),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int rank_limit();
    return (node_ranks < NUM_RANKS) ? int'(node_ranks) : NUM_RANKS;
  endfunction

  function automatic void clear_held();
    for (int r = 0; r < NUM_RANKS; r++) rank_count[r] = 0;
    held_fill = 0;
  endfunction

  // Stores one accepted beat and, on the last one, queues the grouped output.
  function automatic void group_by_rank(input logic [PAYLOAD_W-1:0] p,
                                        input logic [PE_W-1:0] d, input logic l);
    int rk;
    int seg;
    int emitted;
    sorted_beat_t b;
    rk = int'(d) - int'(node_first_pe);
    if (d >= node_first_pe && rk < rank_limit() && held_fill < MSG_CAP) begin
      held_payload[held_fill] = p;
      held_rank[held_fill] = rk[RANK_W-1:0];
      rank_count[rk]++;
      held_fill++;
    end
    if (l) begin
      seg = 0;
      emitted = 0;
      for (int r = 0; r < NUM_RANKS; r++) begin
        seg += rank_count[r];
        if (rank_count[r] != 0) begin
          for (int i = 0; i < held_fill; i++) begin
            if (held_rank[i] == r) begin
              emitted++;
              b.payload = held_payload[i];
              b.rank = r[RANK_W-1:0];
              b.seg_end = seg[SEG_W-1:0];
              b.last = (emitted == held_fill);
              pending_sorted.insert(pending_sorted.size(), b);
            end
          end
        end
      end
      clear_held();
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    sorted_beat_t b;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_sorted.size() == 0) begin
        $error("output beat with nothing expected: payload %h rank %0d",
               out_sorted_payload, out_rank);
        errors++;
      end else begin
        b = pending_sorted.pop_front();
        if (out_sorted_payload !== b.payload) begin
          $error("sorted_payload expected %h actual %h", b.payload, out_sorted_payload);
          errors++;
        end
        if (out_rank !== b.rank) begin
          $error("rank expected %0d actual %0d", b.rank, out_rank);
          errors++;
        end
        if (out_segment_end !== b.seg_end) begin
          $error("segment_end expected %0d actual %0d", b.seg_end, out_segment_end);
          errors++;
        end
        if (out_last_out !== b.last) begin
          $error("last_out expected %b actual %b", b.last, out_last_out);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [PAYLOAD_W-1:0] p, input logic [PE_W-1:0] d,
                           input logic l);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_payload   <= p;
    in_dest_pe   <= d;
    in_last_item <= l;
    do @(posedge clk); while (in_stall);
    group_by_rank(p, d, l);
  endtask

  task automatic wait_sorted_drain();
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FIRST_PE) node_first_pe = val[PE_W-1:0];
    else if (idx == CFG_RANKS_IN_NODE) node_ranks = val[NRANK_W-1:0];
  endtask

  // Upper bits beyond each register's width carry random junk half the time.
  task automatic set_node(input int fp, input int nr);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom_range(1) ? $urandom : '0;
    write_reg(CFG_FIRST_PE, {junk[CFG_DATA_W-1:PE_W], fp[PE_W-1:0]});
    junk = $urandom_range(1) ? $urandom : '0;
    write_reg(CFG_RANKS_IN_NODE, {junk[CFG_DATA_W-1:NRANK_W], nr[NRANK_W-1:0]});
  endtask

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PE_W-1:0] rand_dest();
    logic [PE_W-1:0] d;
    case ($urandom_range(9))
      0:       d = PE_W'($urandom);
      1:       d = node_first_pe - PE_W'(1) - PE_W'($urandom_range(0, 3));
      default: d = node_first_pe + PE_W'($urandom_range(0, rank_limit() + 1));
    endcase
    return d;
  endfunction

  task automatic random_config();
    int fp;
    int nr;
    case ($urandom_range(5))
      0:       fp = 0;
      1:       fp = 4095;
      2:       fp = $urandom_range(4080, 4095);
      default: fp = $urandom_range(0, 4095);
    endcase
    case ($urandom_range(9))
      0:       nr = 0;
      1:       nr = 16;
      2:       nr = 31;
      3:       nr = $urandom_range(17, 31);
      default: nr = $urandom_range(1, 16);
    endcase
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(CFG_RANKS_IN_NODE + 1, 4'hF)), $urandom);
    set_node(fp, nr);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(rand_payload(), rand_dest(), i == len - 1);
  endtask

  task automatic test_reset_defaults();
    send_item('0, 12'd0, 1'b0);
    send_item('1, 12'd1, 1'b0);
    send_item(32'hA5A5_5A5A, 12'd0, 1'b1);
    wait_sorted_drain();
  endtask

  task automatic test_full_node();
    set_node(100, 16);
    send_item(32'h0000_0015, 12'd115, 1'b0);
    send_item(32'h0000_0000, 12'd100, 1'b0);
    send_item(32'hDEAD_BEEF, 12'd99, 1'b0);
    send_item(32'hBAD0_0116, 12'd116, 1'b0);
    send_item(32'h0000_0007, 12'd107, 1'b0);
    send_item(32'hFFFF_FFFF, 12'd100, 1'b0);
    send_item(32'h1234_5678, 12'd4095, 1'b1);
    wait_sorted_drain();
  endtask

  task automatic test_empty_message();
    set_node(4095, 1);
    send_item(32'h5555_5555, 12'd0, 1'b1);
    wait_sorted_drain();
    send_item('1, 12'd4095, 1'b1);
    wait_sorted_drain();
  endtask

  task automatic test_zero_ranks();
    set_node(0, 0);
    send_item(32'h0F0F_0F0F, 12'd0, 1'b0);
    send_item(32'hF0F0_F0F0, 12'd5, 1'b1);
    wait_sorted_drain();
    set_node(10, 31);
    send_item(32'h0000_0025, 12'd25, 1'b0);
    send_item(32'h0000_0026, 12'd26, 1'b0);
    send_item(32'h0000_0010, 12'd10, 1'b1);
    wait_sorted_drain();
  endtask

  task automatic test_mid_message_change();
    set_node(0, 4);
    send_item(32'hAAAA_0003, 12'd3, 1'b0);
    send_item(32'hAAAA_0001, 12'd1, 1'b0);
    wait_sorted_drain();
    set_node(2, 4);
    send_item(32'hBBBB_0002, 12'd2, 1'b0);
    send_item(32'hBBBB_0005, 12'd5, 1'b0);
    send_item(32'hBBBB_0001, 12'd1, 1'b0);
    send_item(32'hBBBB_0004, 12'd4, 1'b1);
    wait_sorted_drain();
  endtask

  task automatic test_store_full();
    set_node($urandom_range(0, 4095), 16);
    send_message($urandom_range(66, 72));
    wait_sorted_drain();
  endtask

  task automatic test_random_messages(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(2) == 0) begin
        wait_sorted_drain();
        random_config();
      end
      len = ($urandom_range(11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
      send_message(len);
      sent += len;
    end
    wait_sorted_drain();
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_payload   <= '0;
    in_dest_pe   <= '0;
    in_last_item <= 1'b0;
    out_stall    <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    node_first_pe = '0;
    node_ranks = NRANK_W'(1);
    clear_held();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_node();
    test_empty_message();
    test_zero_ranks();
    test_mid_message_change();

    idle_pct = 0;  stall_pct = 0;
    test_random_messages(PHASE_ITEMS);
    idle_pct = 67; stall_pct = 0;
    test_random_messages(PHASE_ITEMS);
    idle_pct = 0;  stall_pct = 67;
    test_store_full();
    test_random_messages(PHASE_ITEMS);
    idle_pct = 37; stall_pct = 37;
    test_store_full();
    test_random_messages(PHASE_ITEMS);

    wait_sorted_drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/gibdr_pkg.sv
sv/gibdr_store.sv
sv/group_items_by_dest_rank.sv
bench/tb.sv
